// ===== hw/rtl/fpba_pkg.sv =====
// Shared types and codes for the fit-policy block allocator.
// Used by fpba_cell, fpba_ctrl and fit_policy_block_allocator.
package fpba_pkg;

   localparam int SIZE_W  = 24;
   localparam int ADDR_W  = 24;
   localparam int LIMIT_W = 25;

   localparam logic [LIMIT_W-1:0] LIMIT_CAP = 25'h100_0000;

   // configuration register indexes
   localparam logic CSR_FIT_MODE   = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_mode_type;

   typedef enum logic [2:0] {
      ST_REUSED   = 3'd0,
      ST_GREW     = 3'd1,
      ST_NO_SPACE = 3'd2,
      ST_ZERO     = 3'd3,
      ST_RELEASED = 3'd4,
      ST_NULL     = 3'd5,
      ST_UNKNOWN  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      CELL_NOP,
      CELL_ROTATE,
      CELL_WRITE,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              free;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   data;
   } cell_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_SPLIT,
      S_TAKE,
      S_GROW,
      S_FREE,
      S_DROP_NEXT,
      S_JOIN,
      S_DROP_CUR
   } ctrl_state_type;

endpackage

// ===== hw/rtl/fpba_cell.sv =====
// One table entry of the block chain: payload size and free flag.
// Depends on fpba_pkg for the entry and command types.
module fpba_cell #(
   parameter int IDX_W = 6,
   parameter int IDX   = 0
) (
   input  logic                 clock,
   input  fpba_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]     cmd_idx,
   input  fpba_pkg::entry_type  left,
   input  fpba_pkg::entry_type  right,
   output fpba_pkg::entry_type  q
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   fpba_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         fpba_pkg::CELL_NOP: entry_in = entry_ff;
         fpba_pkg::CELL_ROTATE: entry_in = right;
         fpba_pkg::CELL_WRITE: begin
            if (cmd_idx == MY_IDX) entry_in = cmd.data;
         end
         fpba_pkg::CELL_INSERT: begin
            if (MY_IDX > cmd_idx) entry_in = left;
            else if (MY_IDX == cmd_idx) entry_in = cmd.data;
         end
         fpba_pkg::CELL_DELETE: begin
            if (MY_IDX >= cmd_idx) entry_in = right;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// ===== hw/rtl/fpba_ctrl.sv =====
// Sequencer of the allocator: scans the rotating chain, decides, edits cells.
// Depends on fpba_pkg; drives the fpba_cell row through a broadcast command.
module fpba_ctrl #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24,
   parameter int IW           = $clog2(MAX_BLOCKS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          kind,
   input  logic [fpba_pkg::SIZE_W-1:0]   request_size,
   input  logic [fpba_pkg::ADDR_W-1:0]   payload_address,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [fpba_pkg::LIMIT_W-1:0]  csr_wdata,
   output logic                          rsp_valid,
   output fpba_pkg::status_type          rsp_status,
   output logic [fpba_pkg::ADDR_W-1:0]   rsp_result_address,
   input  fpba_pkg::entry_type           head,
   output fpba_pkg::cell_cmd_type        cell_cmd,
   output logic [IW-1:0]                 cell_idx
);

   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int LW = fpba_pkg::LIMIT_W;
   localparam int SW = fpba_pkg::SIZE_W;
   localparam logic [LW-1:0] HDR     = LW'(HEADER_BYTES);
   localparam logic [LW-1:0] SPLIT_T = LW'(HEADER_BYTES + 4);
   localparam logic [CW-1:0] MAXC    = CW'(MAX_BLOCKS);
   localparam logic [IW-1:0] LAST    = IW'(MAX_BLOCKS - 1);

   fpba_pkg::ctrl_state_type state_ff, state_in;
   fpba_pkg::fit_mode_type   mode_ff, mode_in;
   logic [LW-1:0] limit_ff, limit_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] top_ff, top_in;
   logic [IW-1:0] rover_ff, rover_in;

   logic          kind_ff, kind_in;
   logic [LW-1:0] need_ff, need_in;
   logic [fpba_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [LW-1:0] off_ff, off_in;

   logic          found_ff, found_in;
   logic [IW-1:0] ci_ff, ci_in;
   logic [SW-1:0] cs_ff, cs_in;
   logic [LW-1:0] coff_ff, coff_in;
   logic          fa_ff, fa_in;
   logic [IW-1:0] ai_ff, ai_in;
   logic [SW-1:0] as_ff, as_in;
   logic [LW-1:0] aoff_ff, aoff_in;
   logic          split_ff, split_in;

   logic          ffree_ff, ffree_in;
   logic [SW-1:0] psz_ff, psz_in;
   logic          pfree_ff, pfree_in;
   logic [SW-1:0] prev_s_ff, prev_s_in;
   logic          prev_f_ff, prev_f_in;
   logic          justf_ff, justf_in;
   logic          hasn_ff, hasn_in;
   logic [SW-1:0] nsz_ff, nsz_in;
   logic          nfree_ff, nfree_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   fpba_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [fpba_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   // scan and decision helpers
   logic          entry_valid, fits, main_upd, alt_upd, match;
   logic [IW-1:0] start_idx;
   logic [LW-1:0] lim, grow_sum;
   logic          grow_ok, do_split, merge_next, rel_ok;
   logic [IW-1:0] sel_i;
   logic [SW-1:0] sel_s, new_i;
   logic [LW-1:0] sel_off;

   assign entry_valid = CW'(pos_ff) < count_ff;
   assign fits        = head.free && ({1'b0, head.size} >= need_ff);
   assign start_idx   = (CW'(rover_ff) < count_ff) ? rover_ff : '0;
   assign main_upd    = entry_valid && fits &&
                        (!found_ff ||
                         (mode_ff == fpba_pkg::FIT_BEST  && head.size < cs_ff) ||
                         (mode_ff == fpba_pkg::FIT_WORST && head.size > cs_ff));
   assign alt_upd     = entry_valid && fits && !fa_ff && (pos_ff >= start_idx) &&
                        (mode_ff == fpba_pkg::FIT_NEXT);
   assign match       = entry_valid && !found_ff && (off_ff == {1'b0, addr_ff});

   assign lim      = (limit_ff > fpba_pkg::LIMIT_CAP) ? fpba_pkg::LIMIT_CAP : limit_ff;
   assign grow_sum = top_ff + HDR + need_ff;
   assign grow_ok  = (count_ff < MAXC) && (grow_sum <= lim) && (grow_sum >= top_ff);

   assign sel_i    = fa_ff ? ai_ff : ci_ff;
   assign sel_s    = fa_ff ? as_ff : cs_ff;
   assign sel_off  = fa_ff ? aoff_ff : coff_ff;
   assign do_split = (({1'b0, sel_s} - need_ff) > SPLIT_T) && (count_ff < MAXC);

   assign merge_next = hasn_ff && nfree_ff;
   assign rel_ok     = found_ff && !ffree_ff;
   assign new_i      = merge_next ? SW'({1'b0, cs_ff} + HDR + {1'b0, nsz_ff}) : cs_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpba_pkg::S_IDLE: begin
            if (start) begin
               if (!kind && request_size == '0) state_in = fpba_pkg::S_IDLE;
               else if (kind && payload_address == '0) state_in = fpba_pkg::S_IDLE;
               else state_in = fpba_pkg::S_SCAN;
            end
         end
         fpba_pkg::S_SCAN: begin
            if (pos_ff == LAST) state_in = kind_ff ? fpba_pkg::S_FREE : fpba_pkg::S_ALLOC;
         end
         fpba_pkg::S_ALLOC: begin
            priority if (found_ff && do_split) state_in = fpba_pkg::S_SPLIT;
            else if (found_ff) state_in = fpba_pkg::S_TAKE;
            else if (grow_ok) state_in = fpba_pkg::S_GROW;
            else state_in = fpba_pkg::S_IDLE;
         end
         fpba_pkg::S_SPLIT: state_in = fpba_pkg::S_TAKE;
         fpba_pkg::S_TAKE:  state_in = fpba_pkg::S_IDLE;
         fpba_pkg::S_GROW:  state_in = fpba_pkg::S_IDLE;
         fpba_pkg::S_FREE: begin
            priority if (!rel_ok) state_in = fpba_pkg::S_IDLE;
            else if (merge_next) state_in = fpba_pkg::S_DROP_NEXT;
            else if (pfree_ff) state_in = fpba_pkg::S_JOIN;
            else state_in = fpba_pkg::S_IDLE;
         end
         fpba_pkg::S_DROP_NEXT: state_in = pfree_ff ? fpba_pkg::S_JOIN : fpba_pkg::S_IDLE;
         fpba_pkg::S_JOIN:      state_in = fpba_pkg::S_DROP_CUR;
         fpba_pkg::S_DROP_CUR:  state_in = fpba_pkg::S_IDLE;
         default:               state_in = fpba_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in   = mode_ff;
      limit_in  = limit_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      rover_in  = rover_ff;
      kind_in   = kind_ff;
      need_in   = need_ff;
      addr_in   = addr_ff;
      pos_in    = pos_ff;
      off_in    = off_ff;
      found_in  = found_ff;
      ci_in     = ci_ff;
      cs_in     = cs_ff;
      coff_in   = coff_ff;
      fa_in     = fa_ff;
      ai_in     = ai_ff;
      as_in     = as_ff;
      aoff_in   = aoff_ff;
      split_in  = split_ff;
      ffree_in  = ffree_ff;
      psz_in    = psz_ff;
      pfree_in  = pfree_ff;
      prev_s_in = prev_s_ff;
      prev_f_in = prev_f_ff;
      justf_in  = justf_ff;
      hasn_in   = hasn_ff;
      nsz_in    = nsz_ff;
      nfree_in  = nfree_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      cell_cmd.op   = fpba_pkg::CELL_NOP;
      cell_cmd.data = '0;
      cell_idx      = '0;

      if (csr_we) begin
         unique case (csr_index)
            fpba_pkg::CSR_FIT_MODE:   mode_in  = fpba_pkg::fit_mode_type'(csr_wdata[1:0]);
            fpba_pkg::CSR_HEAP_LIMIT: limit_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         fpba_pkg::S_IDLE: begin
            if (start) begin
               kind_in   = kind;
               need_in   = ({1'b0, request_size} + LW'(3)) & ~LW'(3);
               addr_in   = payload_address;
               pos_in    = '0;
               off_in    = HDR;
               found_in  = 1'b0;
               fa_in     = 1'b0;
               prev_f_in = 1'b0;
               pfree_in  = 1'b0;
               justf_in  = 1'b0;
               hasn_in   = 1'b0;
               if (!kind && request_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = fpba_pkg::ST_ZERO;
                  rsp_addr_in   = '0;
               end else if (kind && payload_address == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = fpba_pkg::ST_NULL;
                  rsp_addr_in   = '0;
               end
            end
         end
         fpba_pkg::S_SCAN: begin
            // ring turns once; head shows entry pos_ff each cycle
            cell_cmd.op = fpba_pkg::CELL_ROTATE;
            pos_in    = pos_ff + IW'(1);
            off_in    = off_ff + HDR + {1'b0, head.size};
            prev_s_in = head.size;
            prev_f_in = head.free;
            justf_in  = 1'b0;
            if (!kind_ff) begin
               if (main_upd) begin
                  found_in = 1'b1;
                  ci_in    = pos_ff;
                  cs_in    = head.size;
                  coff_in  = off_ff;
               end
               if (alt_upd) begin
                  fa_in   = 1'b1;
                  ai_in   = pos_ff;
                  as_in   = head.size;
                  aoff_in = off_ff;
               end
            end else begin
               if (match) begin
                  found_in = 1'b1;
                  ci_in    = pos_ff;
                  cs_in    = head.size;
                  ffree_in = head.free;
                  psz_in   = prev_s_ff;
                  pfree_in = prev_f_ff;
                  justf_in = 1'b1;
               end
               if (justf_ff && entry_valid) begin
                  hasn_in  = 1'b1;
                  nsz_in   = head.size;
                  nfree_in = head.free;
               end
            end
         end
         fpba_pkg::S_ALLOC: begin
            if (found_ff) begin
               ci_in    = sel_i;
               cs_in    = sel_s;
               coff_in  = sel_off;
               split_in = do_split;
            end else if (!grow_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fpba_pkg::ST_NO_SPACE;
               rsp_addr_in   = '0;
            end
         end
         fpba_pkg::S_SPLIT: begin
            cell_cmd.op        = fpba_pkg::CELL_INSERT;
            cell_idx           = ci_ff + IW'(1);
            cell_cmd.data.size = SW'({1'b0, cs_ff} - need_ff - HDR);
            cell_cmd.data.free = 1'b1;
            count_in           = count_ff + CW'(1);
         end
         fpba_pkg::S_TAKE: begin
            cell_cmd.op        = fpba_pkg::CELL_WRITE;
            cell_idx           = ci_ff;
            cell_cmd.data.size = split_ff ? need_ff[SW-1:0] : cs_ff;
            cell_cmd.data.free = 1'b0;
            rover_in           = ci_ff;
            rsp_valid_in       = 1'b1;
            rsp_status_in      = fpba_pkg::ST_REUSED;
            rsp_addr_in        = coff_ff[fpba_pkg::ADDR_W-1:0];
         end
         fpba_pkg::S_GROW: begin
            cell_cmd.op        = fpba_pkg::CELL_WRITE;
            cell_idx           = count_ff[IW-1:0];
            cell_cmd.data.size = need_ff[SW-1:0];
            cell_cmd.data.free = 1'b0;
            rover_in           = count_ff[IW-1:0];
            count_in           = count_ff + CW'(1);
            top_in             = grow_sum;
            rsp_valid_in       = 1'b1;
            rsp_status_in      = fpba_pkg::ST_GREW;
            rsp_addr_in        = fpba_pkg::ADDR_W'(top_ff + HDR);
         end
         fpba_pkg::S_FREE: begin
            if (!rel_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fpba_pkg::ST_UNKNOWN;
               rsp_addr_in   = '0;
            end else begin
               cell_cmd.op        = fpba_pkg::CELL_WRITE;
               cell_idx           = ci_ff;
               cell_cmd.data.size = new_i;
               cell_cmd.data.free = 1'b1;
               cs_in              = new_i;
               if (!merge_next && !pfree_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = fpba_pkg::ST_RELEASED;
                  rsp_addr_in   = '0;
               end
            end
         end
         fpba_pkg::S_DROP_NEXT: begin
            cell_cmd.op = fpba_pkg::CELL_DELETE;
            cell_idx    = ci_ff + IW'(1);
            count_in    = count_ff - CW'(1);
            if (CW'(rover_ff) >= CW'(ci_ff) + CW'(1)) rover_in = rover_ff - IW'(1);
            if (!pfree_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fpba_pkg::ST_RELEASED;
               rsp_addr_in   = '0;
            end
         end
         fpba_pkg::S_JOIN: begin
            cell_cmd.op        = fpba_pkg::CELL_WRITE;
            cell_idx           = ci_ff - IW'(1);
            cell_cmd.data.size = SW'({1'b0, psz_ff} + HDR + {1'b0, cs_ff});
            cell_cmd.data.free = 1'b1;
         end
         fpba_pkg::S_DROP_CUR: begin
            cell_cmd.op = fpba_pkg::CELL_DELETE;
            cell_idx    = ci_ff;
            count_in    = count_ff - CW'(1);
            if (rover_ff >= ci_ff) rover_in = rover_ff - IW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = fpba_pkg::ST_RELEASED;
            rsp_addr_in   = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpba_pkg::S_IDLE;
         mode_ff      <= fpba_pkg::FIT_FIRST;
         limit_ff     <= LW'(65536);
         count_ff     <= '0;
         top_ff       <= '0;
         rover_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rover_ff     <= rover_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      pos_ff        <= pos_in;
      off_ff        <= off_in;
      found_ff      <= found_in;
      ci_ff         <= ci_in;
      cs_ff         <= cs_in;
      coff_ff       <= coff_in;
      fa_ff         <= fa_in;
      ai_ff         <= ai_in;
      as_ff         <= as_in;
      aoff_ff       <= aoff_in;
      split_ff      <= split_in;
      ffree_ff      <= ffree_in;
      psz_ff        <= psz_in;
      pfree_ff      <= pfree_in;
      prev_s_ff     <= prev_s_in;
      prev_f_ff     <= prev_f_in;
      justf_ff      <= justf_in;
      hasn_ff       <= hasn_in;
      nsz_ff        <= nsz_in;
      nfree_ff      <= nfree_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign busy               = (state_ff != fpba_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;

endmodule

// ===== hw/rtl/fit_policy_block_allocator.sv =====
// Zero-size and null words answer in the cycle after start; all others first scan
// the ring of MAX_BLOCKS cells (one cell per cycle). One word at a time: the scan
// rotation of the cell chain sets the rate. The result strobe lasts one cycle; the
// receiver cannot stall. Reset clears block count, heap top, rover and state, sets
// first fit and a heap limit of 65536; cell contents stay unwritten.
// Depends on fpba_pkg, fpba_cell and fpba_ctrl.
module fit_policy_block_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [fpba_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [fpba_pkg::ADDR_W-1:0]   req_payload_address,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [fpba_pkg::ADDR_W-1:0]   rsp_result_address,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [fpba_pkg::LIMIT_W-1:0]  csr_wdata
);

   localparam int IW = $clog2(MAX_BLOCKS);

   fpba_pkg::cell_cmd_type cell_cmd;
   logic [IW-1:0]          cell_idx;
   fpba_pkg::entry_type    q [MAX_BLOCKS];
   fpba_pkg::status_type   status;

   fpba_ctrl #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .HEADER_BYTES(HEADER_BYTES),
      .IW          (IW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .kind              (req_kind),
      .request_size      (req_request_size),
      .payload_address   (req_payload_address),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_status        (status),
      .rsp_result_address(rsp_result_address),
      .head              (q[0]),
      .cell_cmd          (cell_cmd),
      .cell_idx          (cell_idx)
   );

   assign rsp_status = status;

   // ring: right neighbor on rotate, on delete from index up; left on insert above index
   for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
      fpba_cell #(
         .IDX_W(IW),
         .IDX  (j)
      ) u_cell (
         .clock  (clock),
         .cmd    (cell_cmd),
         .cmd_idx(cell_idx),
         .left   (q[(j == 0) ? 0 : j - 1]),
         .right  (q[(j == MAX_BLOCKS - 1) ? 0 : j + 1]),
         .q      (q[j])
      );
   end

endmodule

// ===== tb/fit_policy_block_allocator_tb.sv =====
// Testbench for fit_policy_block_allocator: directed and random allocate/release words,
// checked against a heap table kept in a small scoreboard class.
// Depends on fpba_pkg and the allocator RTL.
module fit_policy_block_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBLK = 64;
   localparam int HDR  = 24;
   localparam int WATCHDOG = 20000;

   typedef struct {
      fpba_pkg::status_type        status;
      logic [fpba_pkg::ADDR_W-1:0] addr;
   } alloc_result_type;

   class heap_scoreboard;
      int unsigned blk_size[NBLK];
      bit          blk_free[NBLK];
      int unsigned blk_cnt, top, rover, mode, limit;
      alloc_result_type pending[$];
      int errors;

      function new();
         blk_cnt = 0; top = 0; rover = 0; mode = 0; limit = 65536; errors = 0;
      endfunction

      function void set_reg(bit idx, int unsigned val);
         if (idx == fpba_pkg::CSR_FIT_MODE) mode = val & 3;
         else limit = val & 32'h1FF_FFFF;
      endfunction

      function int unsigned offset_of(int unsigned idx);
         int unsigned off;
         off = 0;
         for (int k = 0; k < idx; k++) off += HDR + blk_size[k];
         return off + HDR;
      endfunction

      function void drop_entry(int unsigned r);
         for (int k = r; k + 1 < blk_cnt; k++) begin
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
         end
         blk_cnt--;
         if (rover >= r && rover > 0) rover--;
      endfunction

      function int choose(int unsigned need);
         int chosen;
         int unsigned first, idx;
         chosen = -1;
         if (blk_cnt == 0) return -1;
         if (mode == fpba_pkg::FIT_NEXT) begin
            first = rover < blk_cnt ? rover : 0;
            for (int k = 0; k < blk_cnt; k++) begin
               idx = (first + k) % blk_cnt;
               if (blk_free[idx] && blk_size[idx] >= need) return idx;
            end
            return -1;
         end
         for (int k = 0; k < blk_cnt; k++) begin
            if (!blk_free[k] || blk_size[k] < need) continue;
            if (chosen < 0) begin
               chosen = k;
               if (mode == fpba_pkg::FIT_FIRST) return chosen;
            end else if (mode == fpba_pkg::FIT_BEST && blk_size[k] < blk_size[chosen])
               chosen = k;
            else if (mode == fpba_pkg::FIT_WORST && blk_size[k] > blk_size[chosen])
               chosen = k;
         end
         return chosen;
      endfunction

      // note an accepted input word, queue its expected result
      function void note_request(bit kind, int unsigned size, int unsigned addr);
         alloc_result_type r;
         int unsigned need, have, lim, off;
         int pick, found;
         r.addr = 0;
         if (kind == 0) begin
            need = (size + 3) & ~32'd3;
            if (need == 0) r.status = fpba_pkg::ST_ZERO;
            else begin
               pick = choose(need);
               if (pick >= 0) begin
                  have = blk_size[pick];
                  if (have - need > HDR + 4 && blk_cnt < NBLK) begin
                     for (int k = blk_cnt; k > pick + 1; k--) begin
                        blk_size[k] = blk_size[k-1];
                        blk_free[k] = blk_free[k-1];
                     end
                     blk_size[pick+1] = have - need - HDR;
                     blk_free[pick+1] = 1;
                     blk_size[pick] = need;
                     blk_cnt++;
                  end
                  blk_free[pick] = 0;
                  rover = pick;
                  r.status = fpba_pkg::ST_REUSED;
                  r.addr = fpba_pkg::ADDR_W'(offset_of(pick));
               end else begin
                  lim = limit > 32'h100_0000 ? 32'h100_0000 : limit;
                  if (blk_cnt < NBLK && longint'(top) + HDR + need <= longint'(lim)) begin
                     blk_size[blk_cnt] = need;
                     blk_free[blk_cnt] = 0;
                     rover = blk_cnt;
                     blk_cnt++;
                     r.addr = fpba_pkg::ADDR_W'(top + HDR);
                     top += HDR + need;
                     r.status = fpba_pkg::ST_GREW;
                  end else r.status = fpba_pkg::ST_NO_SPACE;
               end
            end
         end else if (addr == 0) r.status = fpba_pkg::ST_NULL;
         else begin
            found = -1;
            off = HDR;
            for (int k = 0; k < blk_cnt; k++) begin
               if (off == addr) begin
                  found = k;
                  break;
               end
               off += HDR + blk_size[k];
            end
            if (found < 0 || blk_free[found]) r.status = fpba_pkg::ST_UNKNOWN;
            else begin
               blk_free[found] = 1;
               if (found + 1 < blk_cnt && blk_free[found+1]) begin
                  blk_size[found] += HDR + blk_size[found+1];
                  drop_entry(found + 1);
               end
               if (found > 0 && blk_free[found-1]) begin
                  blk_size[found-1] += HDR + blk_size[found];
                  drop_entry(found);
               end
               r.status = fpba_pkg::ST_RELEASED;
            end
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [2:0] st, logic [fpba_pkg::ADDR_W-1:0] addr);
         alloc_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word: status %0d address %0d", st, addr);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
         end
         if (addr !== e.addr) begin
            $error("result_address: expected %0d, actual %0d", e.addr, addr);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset, start, busy, req_kind, rsp_valid, csr_we, csr_index;
   logic [fpba_pkg::SIZE_W-1:0]  req_request_size;
   logic [fpba_pkg::ADDR_W-1:0]  req_payload_address, rsp_result_address;
   logic [2:0]                   rsp_status;
   logic [fpba_pkg::LIMIT_W-1:0] csr_wdata;

   heap_scoreboard sb;
   int idle_cycles;
   int items_sent;
   bit calm;
   int unsigned live_addr[$];

   fit_policy_block_allocator dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_status, rsp_result_address);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic write_reg(bit idx, int unsigned val);
      @(negedge clock);
      csr_we = 1; csr_index = idx; csr_wdata = fpba_pkg::LIMIT_W'(val);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic send_word(bit kind, int unsigned size, int unsigned addr);
      if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(negedge clock);
      start = 1; req_kind = kind;
      req_request_size = fpba_pkg::SIZE_W'(size);
      req_payload_address = fpba_pkg::ADDR_W'(addr);
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(kind, size, addr);
      if (kind == 0 && sb.pending[$].addr != 0) live_addr.push_back(sb.pending[$].addr);
      items_sent++;
      @(negedge clock);
      start = 0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (NBLK + 10) @(negedge clock);
   endtask

   task automatic random_word();
      int unsigned sz, pick, a;
      if (live_addr.size() != 0 && $urandom_range(0, 9) < 4) begin
         pick = $urandom_range(0, live_addr.size() - 1);
         a = live_addr[pick];
         live_addr.delete(pick);
         send_word(1, $urandom, a);
      end else if ($urandom_range(0, 19) == 0) begin
         a = $urandom_range(0, 2) == 0 ? 0 : $urandom & 24'hFF_FFFF;
         send_word(1, $urandom, a);
      end else begin
         case ($urandom_range(0, 9))
            0: sz = $urandom & 24'hFF_FFFF;
            1: sz = 0;
            default: sz = $urandom_range(1, 400);
         endcase
         send_word(0, sz, $urandom & 24'hFF_FFFF);
      end
   endtask

   initial begin
      sb = new();
      idle_cycles = 0; items_sent = 0; calm = 0;
      reset = 1; start = 0; req_kind = 0; req_request_size = 0; req_payload_address = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero size, null, unknown, growth, split, merges, oversize
      send_word(0, 0, 0);
      send_word(1, 0, 0);
      send_word(1, 0, 24'hFF_FFFF);
      send_word(0, 1, 0);
      send_word(0, 100, 0);
      send_word(0, 24'hFF_FFFF, 0);
      send_word(0, 8, 0);
      send_word(1, 0, 24 + 4 + 24);
      send_word(1, 0, 24 + 4 + 24);
      send_word(1, 0, 24);
      send_word(0, 20, 0);
      send_word(1, 0, 24 + 4 + 24 + 100 + 24);
      send_word(0, 4, 0);
      drain();
      write_reg(fpba_pkg::CSR_HEAP_LIMIT, 25'h1FF_FFFF);
      send_word(0, 24'hFF_FFFF, 0);
      send_word(0, 24'hFF_FFFF, 0);
      drain();
      write_reg(fpba_pkg::CSR_HEAP_LIMIT, 0);
      send_word(0, 4, 0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(fpba_pkg::CSR_FIT_MODE, ph % 4);
         write_reg(fpba_pkg::CSR_HEAP_LIMIT,
                   ph == 3 ? 25'h100_0000 : $urandom_range(2000, 70000));
         if (ph == 7) calm = 1;
         repeat (60) random_word();
         drain();
      end

      if (sb.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
